FILE: hdl/assert_macros.svh
// Assertion macros used by the index unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, held off during reset.
`define CHI_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("chi assertion failed");

// Next-cycle implication, held off during reset.
`define CHI_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("chi assertion failed");

`else

`define CHI_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define CHI_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

FILE: hdl/chi_pkg.sv
// Types and constants of the chained hash index unit.
package chi_pkg;

    localparam int KEY_W      = 64;
    localparam int NARROW_W   = 32;
    localparam int SLOT_W     = 10;
    localparam int ENTRIES_W  = 11;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_DATA_W-1:0] BUCKET_BITS_MIN   = 4'd2;
    localparam logic [CFG_DATA_W-1:0] BUCKET_BITS_RESET = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_KEYS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BITS = 1'b1;

    // command codes; the spare code behaves as a find
    typedef enum logic [CMD_W-1:0] {
        CMD_FIND = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_DEL  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_CMP,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    slot;
        logic                 valid_slot;
        logic                 table_full;
        logic [ENTRIES_W-1:0] entries;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic head_load;
        logic advance;
        logic set_found;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic head_nil;
        logic key_match;
        logic link_nil;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hdl/chained_hash_index_unit.sv
// Top level of the chained hash index unit.
// Key-to-slot index: find, add or delete one 32- or 64-bit key per item, over chained
// buckets (bucket = key masked to the configured bucket width) and a LIFO free list of
// slots. After reset the unit sweeps the bucket-head table, one entry a cycle, and takes no
// item meanwhile; register writes are taken throughout. Items are handled one at a time: an
// item holds the unit through the accepting cycle, one bucket-head read, one key and link
// read per chain entry compared and a commit step, which waits while a previous result
// still fills the output register. The result sits in an output register, so a new item
// can be taken while the previous result waits. Registers: index 0 wide_keys, index 1
// bucket_bits (clamped to 2..MAX_BUCKET_BITS); write them only while the unit is idle.
`include "assert_macros.svh"

module chained_hash_index_unit import chi_pkg::*; #(
    parameter int SLOTS           = 1024,
    parameter int MAX_BUCKET_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // sequencing: clear sweep, head read, chain walk, commit
    chi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // tables, free list, key compare and result register
    chi_dp #(
        .SLOTS           (SLOTS),
        .MAX_BUCKET_BITS (MAX_BUCKET_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // no item is taken while the bucket heads are still being swept
    `CHI_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, w_cmd.clear_step, !o_in_ready)
    // an accepted item goes straight to its bucket-head read
    `CHI_ASSERT_NEXT(a_accept_then_head, i_clk, i_rst_n, i_in_valid && o_in_ready, w_cmd.head_load)
    // a result is committed only when the output register can take it
    `CHI_ASSERT_NOW(a_finish_needs_room, i_clk, i_rst_n, w_cmd.finish, w_sts.out_free)
    // a result appears only after a commit
    `CHI_ASSERT_NOW(a_out_from_finish, i_clk, i_rst_n, $rose(o_out_valid), $past(w_cmd.finish))

endmodule

FILE: hdl/chi_ctrl.sv
// Controller state machine of the chained hash index unit.
module chi_ctrl import chi_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_HEAD;
            end
            ST_HEAD: begin
                n_state = i_sts.head_nil ? ST_FIN : ST_CMP;
            end
            ST_CMP: begin
                if (i_sts.key_match || i_sts.link_nil) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_HEAD: begin
                o_cmd.head_load = 1'b1;
            end
            ST_CMP: begin
                o_cmd.set_found = i_sts.key_match;
                o_cmd.advance   = !i_sts.key_match && !i_sts.link_nil;
            end
            ST_FIN: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/chi_dp.sv
// Datapath of the chained hash index unit: tables, free list, walk and result register.
module chi_dp import chi_pkg::*; #(
    parameter int SLOTS           = 1024,
    parameter int MAX_BUCKET_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_item,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    localparam int SW      = $clog2(SLOTS);
    localparam int PW      = $clog2(SLOTS + 1);
    localparam int BW      = MAX_BUCKET_BITS;
    localparam int BUCKETS = 2 ** BW;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    // tables
    logic [PW-1:0]    r_bucket_head [BUCKETS];
    logic [PW-1:0]    r_chain_link  [SLOTS];
    logic [PW-1:0]    r_free_link   [SLOTS];
    logic [KEY_W-1:0] r_slot_key    [SLOTS];

    logic [PW-1:0]    r_bh_rd;
    logic [PW-1:0]    r_cl_rd;
    logic [PW-1:0]    r_fl_rd;
    logic [KEY_W-1:0] r_sk_rd;

    // configuration
    logic                  r_wide_keys;
    logic [CFG_DATA_W-1:0] r_bucket_bits;

    // control state
    logic [BW-1:0] r_clr_cnt;
    logic          r_found;
    logic [PW-1:0] r_free_head;
    logic [PW-1:0] r_wmark;
    logic [PW-1:0] r_count;
    logic          r_out_valid;

    // item being worked on
    logic [KEY_W-1:0] r_key;
    logic [CMD_W-1:0] r_cmd;
    logic [BW-1:0]    r_bucket;
    logic [PW-1:0]    r_cur;
    logic [PW-1:0]    r_prev;
    t_out_item        r_out_item;

    logic [CFG_DATA_W-1:0] w_bits;
    logic [BW-1:0]         w_mask;
    logic [KEY_W-1:0]      w_in_key;
    logic [BW-1:0]         n_bucket;
    logic [PW-1:0]         n_cur;
    logic                  w_add_new;
    logic                  w_is_del;
    logic                  w_fh_ok;
    logic                  w_do_add;
    logic                  w_do_del;
    logic                  w_fresh;
    logic [PW-1:0]         w_fh_next;
    logic [PW-1:0]         n_count;
    t_out_item             w_result;

    // clamp the bucket width and build the mask
    always_comb begin
        if (r_bucket_bits < BUCKET_BITS_MIN) begin
            w_bits = BUCKET_BITS_MIN;
        end else if ({1'b0, r_bucket_bits} > 5'(MAX_BUCKET_BITS)) begin
            w_bits = CFG_DATA_W'(MAX_BUCKET_BITS);
        end else begin
            w_bits = r_bucket_bits;
        end
        for (int i = 0; i < BW; i++) begin
            w_mask[i] = ({1'b0, 5'(i)} < {2'b00, w_bits});
        end
    end

    assign w_in_key = r_wide_keys ? i_in_item.key
                                  : {{(KEY_W-NARROW_W){1'b0}}, i_in_item.key[NARROW_W-1:0]};
    assign n_bucket = i_cmd.accept ? (w_in_key[BW-1:0] & w_mask) : r_bucket;

    always_comb begin
        n_cur = r_cur;
        if (i_cmd.head_load) begin
            n_cur = r_bh_rd;
        end else if (i_cmd.advance) begin
            n_cur = r_cl_rd;
        end
    end

    // commit decisions
    assign w_add_new = (r_cmd == CMD_ADD) && !r_found;
    assign w_is_del  = (r_cmd == CMD_DEL) && r_found;
    assign w_fh_ok   = (r_free_head != NIL);
    assign w_do_add  = i_cmd.finish && w_add_new && w_fh_ok;
    assign w_do_del  = i_cmd.finish && w_is_del;
    // slots at or above the mark were never taken: their free link is the next slot
    assign w_fresh   = (r_free_head >= r_wmark);
    assign w_fh_next = w_fresh ? (r_free_head + PW'(1)) : r_fl_rd;

    always_comb begin
        n_count = r_count;
        if (w_add_new && w_fh_ok) begin
            n_count = r_count + PW'(1);
        end else if (w_is_del) begin
            n_count = r_count - PW'(1);
        end
    end

    always_comb begin
        w_result.hit        = r_found;
        w_result.valid_slot = r_found || (w_add_new && w_fh_ok);
        w_result.table_full = w_add_new && !w_fh_ok;
        w_result.entries    = ENTRIES_W'(n_count);
        if (r_found) begin
            w_result.slot = SLOT_W'(r_cur);
        end else if (w_add_new && w_fh_ok) begin
            w_result.slot = SLOT_W'(r_free_head);
        end else begin
            w_result.slot = '0;
        end
    end

    // bucket heads: cleared by the sweep after reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_bucket_head[r_clr_cnt] <= NIL;
        end else if (w_do_add) begin
            r_bucket_head[r_bucket] <= r_free_head;
        end else if (w_do_del && (r_prev == NIL)) begin
            r_bucket_head[r_bucket] <= r_cl_rd;
        end
        r_bh_rd <= r_bucket_head[n_bucket];
    end

    // chain links
    always_ff @(posedge i_clk) begin
        if (w_do_add) begin
            r_chain_link[r_free_head[SW-1:0]] <= r_bh_rd;
        end else if (w_do_del && (r_prev != NIL)) begin
            r_chain_link[r_prev[SW-1:0]] <= r_cl_rd;
        end
        r_cl_rd <= r_chain_link[n_cur[SW-1:0]];
    end

    // stored keys
    always_ff @(posedge i_clk) begin
        if (w_do_add) begin
            r_slot_key[r_free_head[SW-1:0]] <= r_key;
        end
        r_sk_rd <= r_slot_key[n_cur[SW-1:0]];
    end

    // free links, read ahead at the free head
    always_ff @(posedge i_clk) begin
        if (w_do_del) begin
            r_free_link[r_cur[SW-1:0]] <= r_free_head;
        end
        r_fl_rd <= r_free_link[r_free_head[SW-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_keys   <= 1'b0;
            r_bucket_bits <= BUCKET_BITS_RESET;
            r_clr_cnt     <= '0;
            r_found       <= 1'b0;
            r_free_head   <= '0;
            r_wmark       <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDE_KEYS:   r_wide_keys   <= i_cfg_data[0];
                    REG_BUCKET_BITS: r_bucket_bits <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr_cnt <= r_clr_cnt + BW'(1);
            end
            if (i_cmd.head_load) begin
                r_found <= 1'b0;
            end else if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
            if (w_do_add) begin
                r_free_head <= w_fh_next;
                if (w_fresh) r_wmark <= r_free_head + PW'(1);
            end else if (w_do_del) begin
                r_free_head <= r_cur;
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key    <= w_in_key;
            r_cmd    <= i_in_item.command;
        end
        r_bucket <= n_bucket;
        r_cur    <= n_cur;
        if (i_cmd.head_load) begin
            r_prev <= NIL;
        end else if (i_cmd.advance) begin
            r_prev <= r_cur;
        end
        if (i_cmd.finish) begin
            r_out_item <= w_result;
        end
    end

    always_comb begin
        o_sts.clear_done = (r_clr_cnt == '1);
        o_sts.head_nil   = (r_bh_rd == NIL);
        o_sts.link_nil   = (r_cl_rd == NIL);
        o_sts.key_match  = r_wide_keys ? (r_sk_rd == r_key)
                                       : (r_sk_rd[NARROW_W-1:0] == r_key[NARROW_W-1:0]);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the chained hash index unit.
module tb_top;
    import chi_pkg::*;

    // Table geometry mirrored from the unit's default parameters
    localparam int TBL_SLOTS   = 1024;
    localparam int TBL_BUCKETS = 1024;
    localparam int MAX_BB      = 10;
    localparam logic [ENTRIES_W-1:0] NIL = ENTRIES_W'(TBL_SLOTS);

    // Spare command code: the unit treats it as a find
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // Run limit, far beyond the slowest legal run
    localparam int RUN_LIMIT = 50_000_000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    chained_hash_index_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the index: bucket heads, chain links, stored keys, the
    // LIFO free list and the entry count, plus the two registers.
    // ------------------------------------------------------------------
    logic [ENTRIES_W-1:0]  mir_head      [TBL_BUCKETS];
    logic [ENTRIES_W-1:0]  mir_link      [TBL_SLOTS];
    logic [KEY_W-1:0]      mir_key       [TBL_SLOTS];
    logic [ENTRIES_W-1:0]  mir_free_link [TBL_SLOTS];
    logic [ENTRIES_W-1:0]  mir_free_head;
    logic [ENTRIES_W-1:0]  mir_count;
    logic                  mir_wide;
    logic [CFG_DATA_W-1:0] mir_bucket_bits;

    // Results still owed by the unit, oldest first
    t_out_item awaited_results [$];

    int faults        = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 20;

    t_out_item want_item;

    task automatic mirror_reset();
        for (int i = 0; i < TBL_BUCKETS; i++) mir_head[i] = NIL;
        for (int i = 0; i < TBL_SLOTS; i++) begin
            mir_link[i]      = NIL;
            mir_key[i]       = '0;
            mir_free_link[i] = ENTRIES_W'(i + 1);
        end
        mir_free_head   = '0;
        mir_count       = '0;
        mir_wide        = 1'b0;
        mir_bucket_bits = BUCKET_BITS_RESET;
    endtask

    // Out-of-range bucket widths are clamped to 2..MAX_BB
    function automatic int clamped_bits();
        if (mir_bucket_bits < BUCKET_BITS_MIN) return int'(BUCKET_BITS_MIN);
        if (mir_bucket_bits > MAX_BB) return MAX_BB;
        return int'(mir_bucket_bits);
    endfunction

    // Apply one command to the mirror and return the result it owes
    function automatic t_out_item index_mirror_step(t_in_item it);
        logic [KEY_W-1:0]     k;
        logic [ENTRIES_W-1:0] cur;
        logic [ENTRIES_W-1:0] prv;
        logic [ENTRIES_W-1:0] n;
        logic                 found;
        logic                 same;
        int                   bkt;
        int                   steps;
        t_out_item            r;
        k     = mir_wide ? it.key : {32'd0, it.key[NARROW_W-1:0]};
        bkt   = int'(k[MAX_BB-1:0]) & ((1 << clamped_bits()) - 1);
        cur   = mir_head[bkt];
        prv   = NIL;
        found = 1'b0;
        steps = 0;
        // chain walk; narrow mode compares the low half only
        while (cur != NIL && !found && steps < TBL_SLOTS) begin
            same = mir_wide ? (mir_key[cur] == k)
                            : (mir_key[cur][NARROW_W-1:0] == k[NARROW_W-1:0]);
            if (same) begin
                found = 1'b1;
            end else begin
                prv = cur;
                cur = mir_link[cur];
                steps++;
            end
        end
        r            = '0;
        r.hit        = found;
        r.valid_slot = found;
        if (found) r.slot = cur[SLOT_W-1:0];
        if (it.command == CMD_ADD && !found) begin
            if (mir_free_head != NIL) begin
                n                = mir_free_head;
                mir_free_head    = mir_free_link[n];
                mir_key[n]       = k;
                mir_link[n]      = mir_head[bkt];
                mir_head[bkt]    = n;
                mir_count        = mir_count + 1'b1;
                r.slot           = n[SLOT_W-1:0];
                r.valid_slot     = 1'b1;
            end else begin
                r.table_full = 1'b1;
            end
        end else if (it.command == CMD_DEL && found) begin
            if (prv != NIL) mir_link[prv] = mir_link[cur];
            else mir_head[bkt] = mir_link[cur];
            mir_link[cur]      = NIL;
            mir_free_link[cur] = mir_free_head;
            mir_free_head      = cur;
            if (mir_count != 0) mir_count = mir_count - 1'b1;
        end
        r.entries = mir_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order field comparison.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: %p", o_out_item);
                faults++;
            end else begin
                want_item = awaited_results.pop_front();
                if (o_out_item.hit !== want_item.hit) begin
                    $error("hit: expected %0d, got %0d", want_item.hit, o_out_item.hit);
                    faults++;
                end
                if (o_out_item.slot !== want_item.slot) begin
                    $error("slot: expected %0d, got %0d", want_item.slot, o_out_item.slot);
                    faults++;
                end
                if (o_out_item.valid_slot !== want_item.valid_slot) begin
                    $error("valid_slot: expected %0d, got %0d",
                           want_item.valid_slot, o_out_item.valid_slot);
                    faults++;
                end
                if (o_out_item.table_full !== want_item.table_full) begin
                    $error("table_full: expected %0d, got %0d",
                           want_item.table_full, o_out_item.table_full);
                    faults++;
                end
                if (o_out_item.entries !== want_item.entries) begin
                    $error("entries: expected %0d, got %0d",
                           want_item.entries, o_out_item.entries);
                    faults++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // One item: optional idle cycles, then hold valid until the handshake.
    // Valid stays high afterwards so back-to-back items need no re-raise.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        t_in_item it;
        it.command = cmd;
        it.key     = key;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        awaited_results.push_back(index_mirror_step(it));
    endtask

    // Stop sending and wait for every awaited result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    // Both registers, one per cycle; only called with the unit idle.
    // Spare data bits on the width register are filled at random.
    task automatic set_config(logic wide, logic [CFG_DATA_W-1:0] bits);
        logic [CFG_DATA_W-1:0] wdata;
        drain();
        wdata       = {(CFG_DATA_W-1)'($urandom_range(7)), wide};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WIDE_KEYS;
        i_cfg_data  <= wdata;
        @(posedge i_clk);
        mir_wide    = wide;
        i_cfg_index <= REG_BUCKET_BITS;
        i_cfg_data  <= bits;
        @(posedge i_clk);
        mir_bucket_bits = bits;
        i_cfg_we <= 1'b0;
    endtask

    // Random command: adds most often, then deletes and finds, a few spare codes
    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 40) return CMD_ADD;
        if (r < 65) return CMD_FIND;
        if (r < 95) return CMD_DEL;
        return CMD_SPARE;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked chains, aliasing, LIFO reuse, spare code, clamping
    task automatic test_directed();
        set_config(1'b0, 4'd10);
        send_command(CMD_FIND, 64'd0);                   // miss on empty table
        send_command(CMD_DEL,  64'd7);                   // delete of absent key
        send_command(CMD_ADD,  64'd0);                   // slot 0
        send_command(CMD_ADD,  '1);                      // bucket 1023, narrow
        send_command(CMD_ADD,  64'h400);                 // same bucket as 0
        send_command(CMD_FIND, 64'd0);                   // second in chain
        send_command(CMD_ADD,  64'd0);                   // already present
        send_command(CMD_FIND, 64'h1_0000_0000);         // narrow alias of 0
        send_command(CMD_SPARE, 64'h400);                // acts as find
        send_command(CMD_DEL,  64'd0);                   // unlink chain tail
        send_command(CMD_DEL,  64'h400);                 // unlink chain head
        send_command(CMD_ADD,  64'h800);                 // reuses last freed slot
        send_command(CMD_FIND, 64'h400);
        // wide keys: the stored narrow all-ones key has its top half cleared
        set_config(1'b1, 4'd10);
        send_command(CMD_FIND, '1);
        send_command(CMD_FIND, 64'h0000_0000_FFFF_FFFF);
        send_command(CMD_ADD,  64'h8000_0000_0000_0000);
        send_command(CMD_ADD,  64'h1_0000_0000);         // distinct from 0 now
        send_command(CMD_DEL,  64'h8000_0000_0000_0000);
        // bucket width below and above range, no rehash of stored keys
        set_config(1'b0, 4'd0);
        send_command(CMD_FIND, 64'h800);
        send_command(CMD_ADD,  64'h5);
        send_command(CMD_FIND, '1);
        set_config(1'b0, 4'd15);
        send_command(CMD_FIND, 64'h5);
        send_command(CMD_FIND, 64'h800);
        drain();
    endtask

    // Fill every slot, overflow, then free a few slots again in random order;
    // later phases run on the nearly full table.
    task automatic test_fill_and_overflow();
        logic [KEY_W-1:0] filled [$];
        logic [KEY_W-1:0] k;
        int               idx;
        int               n;
        set_config(1'b1, 4'd10);
        n = 0;
        while (mir_count < TBL_SLOTS) begin
            // low bits walk the buckets so chains stay short
            k = {rand_key()} & ~64'h3FF | 64'(n % TBL_BUCKETS);
            filled.push_back(k);
            send_command(CMD_ADD, k);
            n++;
            if (n == TBL_SLOTS / 2) drain();             // sender waits for all
        end
        for (int i = 0; i < 4; i++) send_command(CMD_ADD, rand_key());
        send_command(CMD_ADD,  filled[0]);               // present key, full table
        send_command(CMD_FIND, filled[filled.size() - 1]);
        send_command(CMD_DEL,  filled[3]);
        send_command(CMD_ADD,  rand_key());              // takes the freed slot
        send_command(CMD_ADD,  rand_key());              // full again
        for (int i = 0; i < 48; i++) begin
            idx = $urandom_range(filled.size() - 1);
            send_command(CMD_DEL, filled[idx]);
            filled.delete(idx);
        end
        drain();
    endtask

    // Random traffic on a small key pool so that keys recur, chains collide
    // and narrow aliases appear; some items are noise keys.
    task automatic test_random_phase(logic wide, logic [CFG_DATA_W-1:0] bits, int count);
        logic [KEY_W-1:0] pool [32];
        logic [KEY_W-1:0] mask;
        set_config(wide, bits);
        mask    = (64'd1 << clamped_bits()) - 1;
        pool[0] = rand_key();
        pool[1] = '1;
        pool[2] = '0;
        for (int i = 3; i < 32; i++) begin
            case ($urandom_range(3))
                0: pool[i] = rand_key();
                1: pool[i] = {$urandom, pool[$urandom_range(i - 1)][NARROW_W-1:0]};
                2: pool[i] = (rand_key() & ~mask) | (pool[0] & mask);
                default: pool[i] = 64'($urandom_range(63));
            endcase
        end
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) begin
                send_command(CMD_W'($urandom_range(3)), rand_key());
            end else begin
                send_command(pick_command(), pool[$urandom_range(31)]);
            end
        end
        drain();
    endtask

    initial begin
        mirror_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_overflow();
        test_random_phase(1'b0, 4'd10, 10);
        test_random_phase(1'b1, 4'd2,  10);
        test_random_phase(1'b0, 4'd2,  10);
        test_random_phase(1'b1, 4'd15, 10);
        test_random_phase(1'b0, 4'd1,  10);
        test_random_phase(1'b1, 4'd5,  10);
        test_random_phase(1'b0, 4'(2 + $urandom_range(8)), 10);
        // long stretch with neither side idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(1'b1, 4'd10, 80);

        drain();
        repeat (20) @(posedge i_clk);
        if (faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/chi_pkg.sv
hdl/chi_ctrl.sv
hdl/chi_dp.sv
hdl/chained_hash_index_unit.sv
bench/tb_top.sv
